@@ hw/rtl/i2cm_pkg.sv @@
package i2cm_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 16;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd4;
  localparam logic [4:0] READ_MAX = 5'd16;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_PUSH  = 2'd2,
    ACT_SCAN  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ADDR_NACK = 2'd1,
    ST_DATA_NACK = 2'd2,
    ST_NO_PULLUP = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    JOB_SCAN  = 2'd0,
    JOB_WRITE = 2'd1,
    JOB_READ  = 2'd2
  } job_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_ST_SCL    = 5'd1,
    PH_WB_DATA   = 5'd2,
    PH_WB_HIGH   = 5'd3,
    PH_WB_LOW    = 5'd4,
    PH_WA_REL    = 5'd5,
    PH_WA_HIGH   = 5'd6,
    PH_WA_WAIT   = 5'd7,
    PH_WA_LOW    = 5'd8,
    PH_WA_TAIL   = 5'd9,
    PH_RB_LOW    = 5'd10,
    PH_RB_HIGH   = 5'd11,
    PH_RB_SAMPLE = 5'd12,
    PH_RK_DRIVE  = 5'd13,
    PH_RK_WAIT   = 5'd14,
    PH_RK_HIGH   = 5'd15,
    PH_RK_LOW    = 5'd16,
    PH_SP_SDA    = 5'd17,
    PH_SP_SCL    = 5'd18,
    PH_SP_REL    = 5'd19,
    PH_FINISH    = 5'd20
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] address;
    logic [4:0] write_count;
    logic [4:0] read_count;
    logic [7:0] write_byte;
    logic       sda_level;
  } in_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [1:0] status;
    logic [5:0] byte_total;
  } res_t;

endpackage

@@ hw/rtl/i2cm_in_if.sv @@
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] address;
  logic [4:0] write_count;
  logic [4:0] read_count;
  logic [7:0] write_byte;
  logic       sda_level;

  modport source (
    output valid, action, address, write_count, read_count, write_byte, sda_level,
    input  ready
  );

  modport sink (
    input  valid, action, address, write_count, read_count, write_byte, sda_level,
    output ready
  );
endinterface

@@ hw/rtl/i2cm_out_if.sv @@
interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_low;
  logic       sda_low;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       done_res;
  logic [1:0] status;
  logic [5:0] byte_total;

  modport source (
    output valid, scl_low, sda_low, busy_res, read_valid, read_byte, done_res, status,
           byte_total,
    input  ready
  );

  modport sink (
    input  valid, scl_low, sda_low, busy_res, read_valid, read_byte, done_res, status,
           byte_total,
    output ready
  );
endinterface

@@ hw/rtl/i2cm_seq.sv @@
module i2cm_seq #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  i2cm_pkg::in_t    beat,
  input  logic [15:0]      half_period,
  output i2cm_pkg::res_t   res
);
  import i2cm_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam int XW = (AW > 5) ? AW : 5;
  localparam logic [4:0] WMAX = (BUFFER_DEPTH > 31) ? 5'd31 : 5'(BUFFER_DEPTH);

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rd_data_r;

  phase_t      phase_r, phase_nxt;
  job_t        job_r, job_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [4:0]  bidx_r, bidx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [6:0]  taddr_r, taddr_nxt;
  logic [4:0]  wleft_r, wleft_nxt;
  logic [4:0]  rleft_r, rleft_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        on_addr_r, on_addr_nxt;
  logic        ack_r, ack_nxt;
  status_t     end_st_r, end_st_nxt;

  logic [15:0] hold_load;
  logic [XW-1:0] bidx_ext;
  logic [AW-1:0] rd_addr;
  logic [3:0]  bit_inc;
  logic [4:0]  bidx_inc;
  logic [7:0]  shift_in;
  logic        push_en;
  logic        wr_more;
  logic        rd_valid;
  logic        done;
  status_t     st;
  logic [5:0]  total;

  assign hold_load = (half_period == 16'd0) ? 16'd0 : half_period - 16'd1;
  assign bidx_ext  = XW'(bidx_r);
  assign rd_addr   = bidx_ext[AW-1:0];
  assign bit_inc   = bit_r + 4'd1;
  assign bidx_inc  = bidx_r + 5'd1;
  assign shift_in  = {shift_r[6:0], beat.sda_level};
  assign wr_more   = (bidx_r < wleft_r) && (32'(bidx_r) < BUFFER_DEPTH);
  assign push_en   = step && (phase_r == PH_IDLE) && (beat.action == ACT_PUSH)
                     && (32'(fill_r) < BUFFER_DEPTH);

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[fill_r[AW-1:0]] <= beat.write_byte;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    phase_nxt   = phase_r;
    job_nxt     = job_r;
    hold_nxt    = hold_r;
    bit_nxt     = bit_r;
    bidx_nxt    = bidx_r;
    shift_nxt   = shift_r;
    fill_nxt    = fill_r;
    taddr_nxt   = taddr_r;
    wleft_nxt   = wleft_r;
    rleft_nxt   = rleft_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    on_addr_nxt = on_addr_r;
    ack_nxt     = ack_r;
    end_st_nxt  = end_st_r;
    rd_valid    = 1'b0;
    done        = 1'b0;
    st          = ST_OK;
    total       = 6'd0;
    if (phase_r != PH_IDLE) begin
      if (hold_r != 16'd0) begin
        hold_nxt = hold_r - 16'd1;
      end else begin
        hold_nxt = hold_load;
        case (phase_r)
          PH_ST_SCL: begin
            scl_nxt     = 1'b1;
            shift_nxt   = {taddr_r, job_r == JOB_READ};
            on_addr_nxt = 1'b1;
            bit_nxt     = 4'd0;
            bidx_nxt    = 5'd0;
            phase_nxt   = PH_WB_DATA;
          end
          PH_WB_DATA: begin
            sda_nxt   = ~shift_r[7];
            phase_nxt = PH_WB_HIGH;
          end
          PH_WB_HIGH: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_WB_LOW;
          end
          PH_WB_LOW: begin
            scl_nxt   = 1'b1;
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_inc;
            phase_nxt = (bit_inc >= 4'd8) ? PH_WA_REL : PH_WB_DATA;
          end
          PH_WA_REL: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_WA_HIGH;
          end
          PH_WA_HIGH: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_WA_WAIT;
          end
          PH_WA_WAIT: begin
            phase_nxt = PH_WA_LOW;
          end
          PH_WA_LOW: begin
            ack_nxt   = ~beat.sda_level;
            scl_nxt   = 1'b1;
            phase_nxt = PH_WA_TAIL;
          end
          PH_WA_TAIL: begin
            if (!ack_r) begin
              end_st_nxt = on_addr_r ? ST_ADDR_NACK : ST_DATA_NACK;
              phase_nxt  = PH_SP_SDA;
            end else if (job_r == JOB_SCAN) begin
              end_st_nxt = ST_OK;
              phase_nxt  = PH_SP_SDA;
            end else if (job_r == JOB_WRITE) begin
              if (wr_more) begin
                shift_nxt   = rd_data_r;
                bidx_nxt    = bidx_inc;
                on_addr_nxt = 1'b0;
                bit_nxt     = 4'd0;
                phase_nxt   = PH_WB_DATA;
              end else begin
                end_st_nxt = ST_OK;
                phase_nxt  = PH_SP_SDA;
              end
            end else begin
              bidx_nxt  = 5'd0;
              phase_nxt = PH_RB_LOW;
            end
          end
          PH_RB_LOW: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
            bit_nxt   = 4'd0;
            shift_nxt = 8'd0;
            phase_nxt = PH_RB_HIGH;
          end
          PH_RB_HIGH: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_RB_SAMPLE;
          end
          PH_RB_SAMPLE: begin
            shift_nxt = shift_in;
            scl_nxt   = 1'b1;
            bit_nxt   = bit_inc;
            if (bit_inc >= 4'd8) begin
              rd_valid  = 1'b1;
              phase_nxt = PH_RK_DRIVE;
            end else begin
              phase_nxt = PH_RB_HIGH;
            end
          end
          PH_RK_DRIVE: begin
            sda_nxt   = (bidx_inc < rleft_r);
            phase_nxt = PH_RK_WAIT;
          end
          PH_RK_WAIT: begin
            phase_nxt = PH_RK_HIGH;
          end
          PH_RK_HIGH: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_RK_LOW;
          end
          PH_RK_LOW: begin
            scl_nxt  = 1'b1;
            bidx_nxt = bidx_inc;
            if (bidx_inc < rleft_r) begin
              phase_nxt = PH_RB_LOW;
            end else begin
              end_st_nxt = ST_OK;
              phase_nxt  = PH_SP_SDA;
            end
          end
          PH_SP_SDA: begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_SP_SCL;
          end
          PH_SP_SCL: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_SP_REL;
          end
          PH_SP_REL: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_FINISH;
          end
          PH_FINISH: begin
            if (job_r == JOB_WRITE && end_st_r == ST_OK && rleft_r != 5'd0) begin
              job_nxt   = JOB_READ;
              sda_nxt   = 1'b1;
              phase_nxt = PH_ST_SCL;
            end else begin
              phase_nxt = PH_IDLE;
              hold_nxt  = 16'd0;
              done      = 1'b1;
              st        = end_st_r;
              if (end_st_r == ST_OK && job_r != JOB_SCAN) begin
                total = 6'(wleft_r) + 6'(rleft_r);
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            hold_nxt  = 16'd0;
          end
        endcase
      end
    end else begin
      case (beat.action)
        ACT_PUSH: begin
          if (32'(fill_r) < BUFFER_DEPTH) begin
            fill_nxt = fill_r + FW'(1);
          end
        end
        ACT_START: begin
          taddr_nxt  = beat.address;
          wleft_nxt  = (beat.write_count > WMAX) ? WMAX : beat.write_count;
          rleft_nxt  = (beat.read_count > READ_MAX) ? READ_MAX : beat.read_count;
          fill_nxt   = '0;
          end_st_nxt = ST_OK;
          job_nxt    = JOB_WRITE;
          if (wleft_nxt != 5'd0 || rleft_nxt != 5'd0) begin
            if (wleft_nxt == 5'd0) begin
              job_nxt = JOB_READ;
            end
            sda_nxt   = 1'b1;
            phase_nxt = PH_ST_SCL;
            hold_nxt  = hold_load;
          end else begin
            hold_nxt = 16'd0;
            done     = 1'b1;
          end
        end
        ACT_SCAN: begin
          job_nxt    = JOB_SCAN;
          end_st_nxt = ST_OK;
          if (!beat.sda_level) begin
            hold_nxt = 16'd0;
            done     = 1'b1;
            st       = ST_NO_PULLUP;
          end else begin
            taddr_nxt = beat.address;
            sda_nxt   = 1'b1;
            phase_nxt = PH_ST_SCL;
            hold_nxt  = hold_load;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.scl_low    = scl_nxt;
    res.sda_low    = sda_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.read_valid = rd_valid;
    res.read_byte  = rd_valid ? shift_in : 8'd0;
    res.done_res   = done;
    res.status     = st;
    res.byte_total = total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      job_r     <= JOB_SCAN;
      hold_r    <= 16'd0;
      bit_r     <= 4'd0;
      bidx_r    <= 5'd0;
      shift_r   <= 8'd0;
      fill_r    <= '0;
      taddr_r   <= 7'd0;
      wleft_r   <= 5'd0;
      rleft_r   <= 5'd0;
      scl_r     <= 1'b0;
      sda_r     <= 1'b0;
      on_addr_r <= 1'b0;
      ack_r     <= 1'b0;
      end_st_r  <= ST_OK;
    end else if (step) begin
      phase_r   <= phase_nxt;
      job_r     <= job_nxt;
      hold_r    <= hold_nxt;
      bit_r     <= bit_nxt;
      bidx_r    <= bidx_nxt;
      shift_r   <= shift_nxt;
      fill_r    <= fill_nxt;
      taddr_r   <= taddr_nxt;
      wleft_r   <= wleft_nxt;
      rleft_r   <= rleft_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      on_addr_r <= on_addr_nxt;
      ack_r     <= ack_nxt;
      end_st_r  <= end_st_nxt;
    end
  end

endmodule

@@ hw/rtl/i2c_master_transfer_engine.sv @@
// Open-drain I2C master sequencer driven one tick per input beat. Every accepted beat
// (a plain tick, a start, a write-byte push or an address scan, plus the sampled SDA
// level) yields exactly one result beat with the SCL/SDA pull-down drives, any received
// byte and the done/status/byte count. A beat is accepted every clock cycle: the whole
// sequencer step is one pass of logic from the accepted beat into its state registers
// and a result register, backed by a one-entry skid stage, so input stalls only when
// two results wait downstream. The write buffer is a BUFFER_DEPTH-entry memory with a
// registered read port. Each pin change is held for half_period ticks (zero is treated
// as one); users write half_period via APB port address 0 only while idle, not enforced.
module i2c_master_transfer_engine #(
  parameter int BUFFER_DEPTH = i2cm_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  i2cm_in_if.sink     in_ch,
  i2cm_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import i2cm_pkg::*;

  logic [15:0] half_period_r;
  logic        in_fire;
  in_t         beat;
  res_t        res;
  res_t        out_res_r;
  res_t        skid_res_r;
  logic        out_v_r;
  logic        skid_v_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'(half_period_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      half_period_r <= cfg_pwdata[15:0];
    end
  end

  assign in_ch.ready = !skid_v_r;
  assign in_fire     = in_ch.valid && !skid_v_r;

  assign beat.action      = in_ch.action;
  assign beat.address     = in_ch.address;
  assign beat.write_count = in_ch.write_count;
  assign beat.read_count  = in_ch.read_count;
  assign beat.write_byte  = in_ch.write_byte;
  assign beat.sda_level   = in_ch.sda_level;

  i2cm_seq #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .beat        (beat),
    .half_period (half_period_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r  <= skid_v_r || in_fire;
      skid_v_r <= 1'b0;
    end else if (in_fire) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_res_r <= skid_v_r ? skid_res_r : res;
    end else if (in_fire) begin
      skid_res_r <= res;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.scl_low    = out_res_r.scl_low;
  assign out_ch.sda_low    = out_res_r.sda_low;
  assign out_ch.busy_res   = out_res_r.busy_res;
  assign out_ch.read_valid = out_res_r.read_valid;
  assign out_ch.read_byte  = out_res_r.read_byte;
  assign out_ch.done_res   = out_res_r.done_res;
  assign out_ch.status     = out_res_r.status;
  assign out_ch.byte_total = out_res_r.byte_total;

endmodule

@@ tb/sv/tb_i2c_master_transfer_engine.sv @@
`timescale 1ns / 100ps

import i2cm_pkg::*;

class i2c_tick_scoreboard;
  logic [15:0] half_period = HALF_PERIOD_RESET;
  phase_t      ph = PH_IDLE;
  int unsigned hold = 0;
  int unsigned bit_cnt = 0;
  int unsigned byte_idx = 0;
  logic [7:0]  shreg = '0;
  logic [7:0]  wbuf [DEFAULT_BUFFER_DEPTH];
  int unsigned fill = 0;
  int unsigned written = 0;
  logic [6:0]  target = '0;
  int unsigned writes_left = 0;
  int unsigned reads_left = 0;
  logic        scl_d = 1'b0;
  logic        sda_d = 1'b0;
  job_t        job = JOB_SCAN;
  bit          on_addr = 1'b0;
  bit          got_ack = 1'b0;
  status_t     end_st = ST_OK;
  res_t        cur;
  res_t        pending [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned reads_seen = 0;
  int unsigned done_by_status [4] = '{0, 0, 0, 0};

  function void reload();
    hold = (half_period == 16'd0) ? 0 : half_period - 1;
  endfunction

  function void begin_bus();
    sda_d = 1'b1;
    ph = PH_ST_SCL;
    reload();
  endfunction

  function void stop_with(status_t st);
    end_st = st;
    ph = PH_SP_SDA;
  endfunction

  function void finish_job(status_t st);
    ph = PH_IDLE;
    hold = 0;
    cur.done_res = 1'b1;
    cur.status = st;
    cur.byte_total = (st == ST_OK && job != JOB_SCAN) ? 6'(writes_left + reads_left) : 6'd0;
    done_by_status[st]++;
  endfunction

  function void bus_step(logic sda);
    bit skip;
    skip = 1'b0;
    case (ph)
      PH_ST_SCL: begin
        scl_d = 1'b1;
        shreg = {target, job == JOB_READ};
        on_addr = 1'b1;
        bit_cnt = 0;
        byte_idx = 0;
        ph = PH_WB_DATA;
      end
      PH_WB_DATA: begin
        sda_d = ~shreg[7];
        ph = PH_WB_HIGH;
      end
      PH_WB_HIGH: begin
        scl_d = 1'b0;
        ph = PH_WB_LOW;
      end
      PH_WB_LOW: begin
        scl_d = 1'b1;
        shreg = shreg << 1;
        bit_cnt++;
        ph = (bit_cnt >= 8) ? PH_WA_REL : PH_WB_DATA;
      end
      PH_WA_REL: begin
        sda_d = 1'b0;
        ph = PH_WA_HIGH;
      end
      PH_WA_HIGH: begin
        scl_d = 1'b0;
        ph = PH_WA_WAIT;
      end
      PH_WA_WAIT: ph = PH_WA_LOW;
      PH_WA_LOW: begin
        got_ack = (sda == 1'b0);
        scl_d = 1'b1;
        ph = PH_WA_TAIL;
      end
      PH_WA_TAIL: begin
        if (!got_ack) begin
          stop_with(on_addr ? ST_ADDR_NACK : ST_DATA_NACK);
        end else if (job == JOB_SCAN) begin
          stop_with(ST_OK);
        end else if (job == JOB_WRITE) begin
          if (byte_idx < writes_left && byte_idx < DEFAULT_BUFFER_DEPTH) begin
            shreg = wbuf[byte_idx];
            byte_idx++;
            on_addr = 1'b0;
            bit_cnt = 0;
            ph = PH_WB_DATA;
          end else begin
            stop_with(ST_OK);
          end
        end else begin
          byte_idx = 0;
          ph = PH_RB_LOW;
        end
      end
      PH_RB_LOW: begin
        scl_d = 1'b1;
        sda_d = 1'b0;
        bit_cnt = 0;
        shreg = '0;
        ph = PH_RB_HIGH;
      end
      PH_RB_HIGH: begin
        scl_d = 1'b0;
        ph = PH_RB_SAMPLE;
      end
      PH_RB_SAMPLE: begin
        shreg = {shreg[6:0], sda};
        scl_d = 1'b1;
        bit_cnt++;
        if (bit_cnt >= 8) begin
          cur.read_valid = 1'b1;
          cur.read_byte = shreg;
          reads_seen++;
          ph = PH_RK_DRIVE;
        end else begin
          ph = PH_RB_HIGH;
        end
      end
      PH_RK_DRIVE: begin
        sda_d = (byte_idx + 1 < reads_left);
        ph = PH_RK_WAIT;
      end
      PH_RK_WAIT: ph = PH_RK_HIGH;
      PH_RK_HIGH: begin
        scl_d = 1'b0;
        ph = PH_RK_LOW;
      end
      PH_RK_LOW: begin
        scl_d = 1'b1;
        byte_idx++;
        if (byte_idx < reads_left) begin
          ph = PH_RB_LOW;
        end else begin
          stop_with(ST_OK);
        end
      end
      PH_SP_SDA: begin
        sda_d = 1'b1;
        ph = PH_SP_SCL;
      end
      PH_SP_SCL: begin
        scl_d = 1'b0;
        ph = PH_SP_REL;
      end
      PH_SP_REL: begin
        sda_d = 1'b0;
        ph = PH_FINISH;
      end
      PH_FINISH: begin
        skip = 1'b1;
        // a good write phase with reads left hands over to the read phase
        if (job == JOB_WRITE && end_st == ST_OK && reads_left > 0) begin
          job = JOB_READ;
          begin_bus();
        end else begin
          finish_job(end_st);
        end
      end
      default: begin
        skip = 1'b1;
        ph = PH_IDLE;
        hold = 0;
      end
    endcase
    if (!skip) reload();
  endfunction

  function void take_beat(in_t b);
    cur = '0;
    if (ph != PH_IDLE) begin
      if (hold > 0) hold--;
      else bus_step(b.sda_level);
    end else begin
      case (b.action)
        ACT_PUSH: begin
          if (fill < DEFAULT_BUFFER_DEPTH) begin
            wbuf[fill] = b.write_byte;
            fill++;
            if (fill > written) written = fill;
          end
        end
        ACT_START: begin
          target = b.address;
          writes_left = (b.write_count > DEFAULT_BUFFER_DEPTH) ? DEFAULT_BUFFER_DEPTH
                                                               : b.write_count;
          reads_left = (b.read_count > READ_MAX) ? READ_MAX : b.read_count;
          fill = 0;
          end_st = ST_OK;
          if (writes_left > 0) begin
            job = JOB_WRITE;
            begin_bus();
          end else if (reads_left > 0) begin
            job = JOB_READ;
            begin_bus();
          end else begin
            job = JOB_WRITE;
            finish_job(ST_OK);
          end
        end
        ACT_SCAN: begin
          job = JOB_SCAN;
          end_st = ST_OK;
          if (b.sda_level != 1'b1) begin
            finish_job(ST_NO_PULLUP);
          end else begin
            target = b.address;
            begin_bus();
          end
        end
        default: ;
      endcase
    end
    cur.scl_low = scl_d;
    cur.sda_low = sda_d;
    cur.busy_res = (ph != PH_IDLE);
    pending.push_back(cur);
  endfunction

  function string show(res_t r);
    return {$sformatf("scl_low=%0b sda_low=%0b busy=%0b rvalid=%0b rbyte=%02h ",
                      r.scl_low, r.sda_low, r.busy_res, r.read_valid, r.read_byte),
            $sformatf("done=%0b st=%0d tot=%0d", r.done_res, r.status, r.byte_total)};
  endfunction

  function void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH %s", msg);
  endfunction

  function void match_result(res_t got);
    res_t want;
    results_seen++;
    if (pending.size() == 0) begin
      note_mismatch($sformatf("result %0d with nothing pending: %s", results_seen, show(got)));
      return;
    end
    want = pending.pop_front();
    if (got.scl_low !== want.scl_low || got.sda_low !== want.sda_low ||
        got.busy_res !== want.busy_res || got.read_valid !== want.read_valid ||
        got.read_byte !== want.read_byte || got.done_res !== want.done_res ||
        got.status !== want.status || got.byte_total !== want.byte_total) begin
      note_mismatch($sformatf("result %0d: expected %s / got %s", results_seen, show(want),
                              show(got)));
    end
  endfunction
endclass

module tb_i2c_master_transfer_engine;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0] REG_HALF_PERIOD = 2'd0;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();

  i2c_master_transfer_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  i2c_tick_scoreboard sb;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles = 0;
  int unsigned beats_sent = 0;
  logic        ack_plan [$];
  int unsigned hp_plan [7] = '{1, 0, 2, 65535, 3, 1, 2};
  int unsigned idle_plan [7] = '{0, 46, 0, 18, 18, 46, 0};
  int unsigned stall_plan [7] = '{0, 0, 46, 18, 18, 0, 46};
  int unsigned beat_plan [7] = '{60, 60, 60, 40, 60, 60, 60};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.match_result({out_ch.scl_low, out_ch.sda_low, out_ch.busy_res, out_ch.read_valid,
                       out_ch.read_byte, out_ch.done_res, out_ch.status, out_ch.byte_total});
    end
  end

  // slave response: mostly acks, scripted where a case needs a given ack or nack
  function automatic logic pick_sda();
    if (sb.ph == PH_WA_LOW && sb.hold == 0) begin
      if (ack_plan.size() != 0) return ack_plan.pop_front();
      return ($urandom_range(99) < 90) ? 1'b0 : 1'b1;
    end
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [4:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 5'($urandom_range(2));
    if (r < 95) return 5'($urandom_range(6));
    return 5'($urandom_range(31));
  endfunction

  function automatic in_t cmd(act_t a, logic [6:0] ad, logic [4:0] wc, logic [4:0] rc,
                              logic [7:0] wb, logic sda);
    in_t b;
    b.action = a;
    b.address = ad;
    b.write_count = wc;
    b.read_count = rc;
    b.write_byte = wb;
    b.sda_level = sda;
    return b;
  endfunction

  function automatic in_t make_beat(bit quick);
    in_t b;
    int r;
    b = cmd(ACT_TICK, 7'($urandom_range(127)), 5'($urandom_range(31)),
            5'($urandom_range(31)), 8'($urandom_range(255)), pick_sda());
    r = $urandom_range(99);
    if (sb.ph != PH_IDLE) begin
      if (r < 8) b.action = 2'($urandom_range(ACT_SCAN, ACT_START));
    end else if (r < 12) begin
      b.action = ACT_TICK;
    end else if (r < 45) begin
      b.action = ACT_PUSH;
    end else if (r < 80) begin
      b.action = ACT_START;
      b.write_count = quick ? 5'd0 : pick_count();
      b.read_count = quick ? 5'd0 : pick_count();
    end else begin
      b.action = ACT_SCAN;
      b.sda_level = quick ? 1'b0 : ($urandom_range(99) < 85);
    end
    return b;
  endfunction

  task automatic send(in_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= b.action;
    in_ch.address <= b.address;
    in_ch.write_count <= b.write_count;
    in_ch.read_count <= b.read_count;
    in_ch.write_byte <= b.write_byte;
    in_ch.sda_level <= b.sda_level;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.take_beat(b);
    beats_sent++;
  endtask

  task automatic run_idle();
    while (sb.ph != PH_IDLE) send(make_beat(1'b0));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic set_half_period(logic [15:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_HALF_PERIOD;
    cfg_pwdata <= {16'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    sb.half_period = v;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== {16'd0, v}) begin
      sb.note_mismatch($sformatf("half_period readback %08h, expected %08h", cfg_prdata,
                                 {16'd0, v}));
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic run_directed();
    int i;
    // shortest hold keeps the full-length transfer brief
    set_half_period(16'd1);
    // fill the buffer, the last push finds it full
    for (i = 0; i <= DEFAULT_BUFFER_DEPTH; i++) begin
      send(cmd(ACT_PUSH, 7'h7F, 5'd31, 5'd31,
               (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(255)), i[0]));
    end
    repeat (18) ack_plan.push_back(1'b0);
    send(cmd(ACT_START, 7'h7F, 5'd31, 5'd31, 8'hFF, 1'b1));
    // dropped while busy
    send(cmd(ACT_PUSH, 7'h00, 5'd0, 5'd0, 8'h5A, 1'b0));
    send(cmd(ACT_SCAN, 7'h01, 5'd1, 5'd1, 8'h00, 1'b1));
    run_idle();
    send(cmd(ACT_START, 7'h12, 5'd0, 5'd0, 8'h00, 1'b0));
    ack_plan.push_back(1'b0);
    send(cmd(ACT_START, 7'h00, 5'd0, 5'd1, 8'h00, 1'b0));
    run_idle();
    // address nack, then data nack
    ack_plan.push_back(1'b1);
    send(cmd(ACT_START, 7'h33, 5'd1, 5'd0, 8'h00, 1'b0));
    run_idle();
    ack_plan.push_back(1'b0);
    ack_plan.push_back(1'b1);
    send(cmd(ACT_START, 7'h4C, 5'd2, 5'd2, 8'h00, 1'b0));
    run_idle();
    send(cmd(ACT_SCAN, 7'h55, 5'd0, 5'd0, 8'h00, 1'b0));
    ack_plan.push_back(1'b0);
    send(cmd(ACT_SCAN, 7'h55, 5'd0, 5'd0, 8'h00, 1'b1));
    run_idle();
    ack_plan.push_back(1'b1);
    send(cmd(ACT_SCAN, 7'h2A, 5'd0, 5'd0, 8'h00, 1'b1));
    run_idle();
  endtask

  initial begin
    int p;
    int i;
    sb = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_TICK;
    in_ch.address <= '0;
    in_ch.write_count <= '0;
    in_ch.read_count <= '0;
    in_ch.write_byte <= '0;
    in_ch.sda_level <= 1'b1;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= REG_HALF_PERIOD;
    cfg_pwdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (p = 0; p < 7; p++) begin
      settle();
      set_half_period(16'(hp_plan[p]));
      idle_pct = idle_plan[p];
      stall_pct = stall_plan[p];
      for (i = 0; i < beat_plan[p]; i++) begin
        if ($urandom_range(199) == 0) settle();
        // with the longest hold only commands that finish at once are issued
        send(make_beat(hp_plan[p] == 65535));
      end
      run_idle();
    end

    settle();
    repeat (20) @(posedge clk);
    $display("%0d beats over the directed run and 7 hold phases: %0d ok, %0d address nack,",
             beats_sent, sb.done_by_status[ST_OK], sb.done_by_status[ST_ADDR_NACK]);
    $display("%0d data nack, %0d no pull-up, %0d bytes read, %0d results, %0d mismatches",
             sb.done_by_status[ST_DATA_NACK], sb.done_by_status[ST_NO_PULLUP],
             sb.reads_seen, sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
